// ----- rtl/core/psf_pkg.sv -----
// Shared widths, stage structs and saturation helper for the spring force pipeline.
package psf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 32;
    localparam int D_W       = POS_W + 1;
    localparam int MAG_W     = D_W;
    localparam int SUM_W     = 2 * MAG_W;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int X_W       = ROOT_W + 1;
    localparam int KP_W      = POS_W + ROOT_W;
    localparam int KX_W      = KP_W - FRAC_BITS;
    localparam int U_W       = FRAC_BITS + 1;
    localparam int PR_W      = KX_W + U_W;
    localparam int FM_W      = PR_W - FRAC_BITS;

    localparam int LAT_FRONT = 3;
    localparam int LAT_DIV   = U_W + 1;
    localparam int LAT_BACK  = 2;
    localparam int LAT       = LAT_FRONT + ROOT_W + LAT_DIV + LAT_BACK;

    localparam logic [FM_W-1:0] SAT_NEG = FM_W'(1) << (POS_W - 1);
    localparam logic [FM_W-1:0] SAT_POS = SAT_NEG - FM_W'(1);

    typedef struct packed {
        logic [2:0][D_W-1:0] d;
        logic [POS_W-1:0]    rest;
        logic [POS_W-1:0]    k;
    } t_side;

    typedef struct packed {
        logic [KX_W-1:0]   kx;
        logic [ROOT_W-1:0] len;
        logic              xneg;
        logic [2:0]        dneg;
        logic [POS_W-1:0]  stretch;
        logic [POS_W-1:0]  span;
        logic              degen;
    } t_mid;

    typedef struct packed {
        logic [2:0][POS_W-1:0] frc;
        logic [POS_W-1:0]      stretch;
        logic [POS_W-1:0]      span;
        logic                  degen;
    } t_res;

    // sign and magnitude to saturated two's complement
    function automatic logic [POS_W-1:0] sat_s(input logic neg, input logic [FM_W-1:0] m);
        logic [POS_W-1:0] r;
        if (neg) begin
            if (m > SAT_NEG) r = SAT_NEG[POS_W-1:0];
            else r = -m[POS_W-1:0];
        end else begin
            if (m > SAT_POS) r = SAT_POS[POS_W-1:0];
            else r = m[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/psf_in_if.sv -----
// Input channel: two positions, rest length and stiffness.
interface psf_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [psf_pkg::POS_W-1:0] pos_a_x;
    logic signed [psf_pkg::POS_W-1:0] pos_a_y;
    logic signed [psf_pkg::POS_W-1:0] pos_a_z;
    logic signed [psf_pkg::POS_W-1:0] pos_b_x;
    logic signed [psf_pkg::POS_W-1:0] pos_b_y;
    logic signed [psf_pkg::POS_W-1:0] pos_b_z;
    logic        [psf_pkg::POS_W-1:0] rest_length;
    logic        [psf_pkg::POS_W-1:0] spring_constant;

    modport source (output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
                    rest_length, spring_constant, input ready);
    modport sink   (input valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
                    rest_length, spring_constant, output ready);
endinterface

// ----- rtl/core/psf_out_if.sv -----
// Output channel: force on B, stretch, distance and degenerate flag.
interface psf_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [psf_pkg::POS_W-1:0] force_x;
    logic signed [psf_pkg::POS_W-1:0] force_y;
    logic signed [psf_pkg::POS_W-1:0] force_z;
    logic signed [psf_pkg::POS_W-1:0] stretch;
    logic        [psf_pkg::POS_W-1:0] distance;
    logic                             degenerate;

    modport source (output valid, force_x, force_y, force_z, stretch, distance, degenerate,
                    input ready);
    modport sink   (input valid, force_x, force_y, force_z, stretch, distance, degenerate,
                    output ready);
endinterface

// ----- rtl/core/psf_front.sv -----
// Front stages: separation, squares, sum of squares.
module psf_front (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [2:0][psf_pkg::POS_W-1:0]       i_pa,
    input  logic [2:0][psf_pkg::POS_W-1:0]       i_pb,
    input  logic [psf_pkg::POS_W-1:0]            i_rest,
    input  logic [psf_pkg::POS_W-1:0]            i_k,
    output logic [psf_pkg::SUM_W-1:0]            o_sum,
    output psf_pkg::t_side                       o_side
);

    psf_pkg::t_side                          r_s1, r_s2, r_s3, n_s1;
    logic [2:0][psf_pkg::SUM_W-1:0]          r_sq, n_sq;
    logic [psf_pkg::SUM_W-1:0]               r_sum;
    logic [2:0][psf_pkg::MAG_W-1:0]          w_mag;

    always_comb begin
        n_s1.rest = i_rest;
        n_s1.k    = i_k;
        for (int i = 0; i < 3; i++) begin
            n_s1.d[i] = {i_pa[i][psf_pkg::POS_W-1], i_pa[i]}
                      - {i_pb[i][psf_pkg::POS_W-1], i_pb[i]};
        end
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_s1.d[i][psf_pkg::D_W-1] ? -r_s1.d[i] : r_s1.d[i];
            n_sq[i]  = psf_pkg::SUM_W'(w_mag[i]) * psf_pkg::SUM_W'(w_mag[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1  <= n_s1;
            r_sq  <= n_sq;
            r_s2  <= r_s1;
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
            r_s3  <= r_s2;
        end
    end

    assign o_sum  = r_sum;
    assign o_side = r_s3;

endmodule

// ----- rtl/core/psf_sqrt.sv -----
// Pipelined restoring integer square root, one root bit per stage.
module psf_sqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [psf_pkg::SUM_W-1:0]     i_sum,
    input  psf_pkg::t_side                i_side,
    output logic [psf_pkg::ROOT_W-1:0]    o_root,
    output psf_pkg::t_side                o_side
);

    localparam int NS = psf_pkg::ROOT_W;

    logic [psf_pkg::REM_W-1:0]  r_rem  [NS];
    logic [psf_pkg::ROOT_W-1:0] r_root [NS];
    logic [psf_pkg::SUM_W-1:0]  r_rad  [NS];
    psf_pkg::t_side             r_side [NS];

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic [psf_pkg::REM_W-1:0]  w_rem, w_r2, w_t;
        logic [psf_pkg::ROOT_W-1:0] w_root;
        logic [psf_pkg::SUM_W-1:0]  w_rad;
        psf_pkg::t_side             w_side;

        if (g == 0) begin : g_first
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_rad  = i_sum;
            assign w_side = i_side;
        end else begin : g_next
            assign w_rem  = r_rem[g-1];
            assign w_root = r_root[g-1];
            assign w_rad  = r_rad[g-1];
            assign w_side = r_side[g-1];
        end

        // bring down the next two radicand bits, trial subtract 4r+1
        assign w_r2 = {w_rem[psf_pkg::REM_W-3:0], w_rad[psf_pkg::SUM_W-1 -: 2]};
        assign w_t  = {w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_r2 >= w_t) begin
                    r_rem[g]  <= w_r2 - w_t;
                    r_root[g] <= {w_root[psf_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[g]  <= w_r2;
                    r_root[g] <= {w_root[psf_pkg::ROOT_W-2:0], 1'b0};
                end
                r_rad[g]  <= w_rad << 2;
                r_side[g] <= w_side;
            end
        end
    end

    assign o_root = r_root[NS-1];
    assign o_side = r_side[NS-1];

endmodule

// ----- rtl/core/psf_div.sv -----
// Stretch stage, k*|x| product and three pipelined unit-vector dividers.
module psf_div (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [psf_pkg::ROOT_W-1:0]         i_root,
    input  psf_pkg::t_side                     i_side,
    output logic [2:0][psf_pkg::U_W-1:0]       o_quo,
    output psf_pkg::t_mid                      o_mid
);

    localparam int NS = psf_pkg::U_W;

    typedef struct packed {
        logic [psf_pkg::POS_W-1:0]       k;
        logic [psf_pkg::ROOT_W-1:0]      xm;
        logic [2:0][psf_pkg::MAG_W-1:0]  mag;
        psf_pkg::t_mid                   m;
    } t_ent;

    t_ent                       r_e, n_e;
    logic [psf_pkg::X_W-1:0]    w_x, w_xa;

    logic [2:0][psf_pkg::ROOT_W-1:0] r_rem [NS];
    logic [2:0][psf_pkg::U_W-1:0]    r_nb  [NS];
    logic [2:0][psf_pkg::U_W-1:0]    r_q   [NS];
    psf_pkg::t_mid                   r_m   [NS];

    always_comb begin
        w_x  = psf_pkg::X_W'(i_root) - psf_pkg::X_W'(i_side.rest);
        w_xa = w_x[psf_pkg::X_W-1] ? -w_x : w_x;
        n_e.k      = i_side.k;
        n_e.xm     = w_xa[psf_pkg::ROOT_W-1:0];
        n_e.m.kx   = '0;
        n_e.m.len  = i_root;
        n_e.m.xneg = w_x[psf_pkg::X_W-1];
        for (int i = 0; i < 3; i++) begin
            n_e.m.dneg[i] = i_side.d[i][psf_pkg::D_W-1];
            n_e.mag[i]    = n_e.m.dneg[i] ? -i_side.d[i] : i_side.d[i];
        end
        n_e.m.stretch = psf_pkg::sat_s(w_x[psf_pkg::X_W-1], psf_pkg::FM_W'(n_e.xm));
        n_e.m.span    = (i_root[psf_pkg::ROOT_W-1:psf_pkg::POS_W] != '0) ? '1
                        : i_root[psf_pkg::POS_W-1:0];
        n_e.m.degen   = (i_root == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e <= n_e;
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic [2:0][psf_pkg::ROOT_W-1:0] w_rem;
        logic [2:0][psf_pkg::U_W-1:0]    w_nb, w_q;
        psf_pkg::t_mid                   w_m;

        if (g == 0) begin : g_first
            logic [psf_pkg::KP_W-1:0] w_kp;
            assign w_kp = psf_pkg::KP_W'(r_e.k) * psf_pkg::KP_W'(r_e.xm);
            always_comb begin
                w_m    = r_e.m;
                w_m.kx = w_kp[psf_pkg::KP_W-1:psf_pkg::FRAC_BITS];
                for (int i = 0; i < 3; i++) begin
                    // quotient fits U_W bits, so the top part starts below len
                    w_rem[i] = psf_pkg::ROOT_W'(r_e.mag[i][psf_pkg::MAG_W-1:1]);
                    w_nb[i]  = {r_e.mag[i][0], {psf_pkg::FRAC_BITS{1'b0}}};
                    w_q[i]   = '0;
                end
            end
        end else begin : g_next
            assign w_rem = r_rem[g-1];
            assign w_nb  = r_nb[g-1];
            assign w_q   = r_q[g-1];
            assign w_m   = r_m[g-1];
        end

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [psf_pkg::ROOT_W:0] w_r2;
            assign w_r2 = {w_rem[l], w_nb[l][psf_pkg::U_W-1]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (w_r2 >= {1'b0, w_m.len}) begin
                        r_rem[g][l] <= psf_pkg::ROOT_W'(w_r2 - {1'b0, w_m.len});
                        r_q[g][l]   <= {w_q[l][psf_pkg::U_W-2:0], 1'b1};
                    end else begin
                        r_rem[g][l] <= w_r2[psf_pkg::ROOT_W-1:0];
                        r_q[g][l]   <= {w_q[l][psf_pkg::U_W-2:0], 1'b0};
                    end
                    r_nb[g][l] <= w_nb[l] << 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[g] <= w_m;
            end
        end
    end

    assign o_quo = r_q[NS-1];
    assign o_mid = r_m[NS-1];

endmodule

// ----- rtl/core/psf_back.sv -----
// Back stages: k*x times unit vector, sign and saturation.
module psf_back (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [2:0][psf_pkg::U_W-1:0]     i_quo,
    input  psf_pkg::t_mid                    i_mid,
    output psf_pkg::t_res                    o_res
);

    logic [2:0][psf_pkg::PR_W-1:0] r_prod, n_prod;
    psf_pkg::t_mid                 r_pm;
    psf_pkg::t_res                 r_res, n_res;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_prod[i] = psf_pkg::PR_W'(i_mid.kx) * psf_pkg::PR_W'(i_quo[i]);
        end
        n_res.stretch = r_pm.stretch;
        n_res.span    = r_pm.span;
        n_res.degen   = r_pm.degen;
        for (int i = 0; i < 3; i++) begin
            n_res.frc[i] = r_pm.degen ? '0
                : psf_pkg::sat_s(r_pm.xneg ^ r_pm.dneg[i],
                                 r_prod[i][psf_pkg::PR_W-1:psf_pkg::FRAC_BITS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_pm   <= i_mid;
            r_res  <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ----- rtl/core/paired_spring_force_unit.sv -----
// Hooke spring force between two 3D points: top level with pipeline valid chain.
//
// One word in, one word out, one word per clock sustained; values are Q16.16.
// The pipe holds 3 front stages (difference, square, sum), 33 square-root
// stages at one root bit each, an entry stage, 17 divider stages at one
// quotient bit each for the unit vector, and 2 back stages (product,
// saturation). The root and divider chains set the depth.
// The whole pipe advances together and holds on a stall of the output; the
// final stage is the output register, so while a finished word waits there
// the whole pipe and the input stall, bubbles or not. Coinciding points
// give zero force with the degenerate flag set.
module paired_spring_force_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    psf_in_if.sink          i_in,
    psf_out_if.source       o_out
);

    localparam int LAT = psf_pkg::LAT;

    logic [LAT-1:0]                    r_vld;
    logic                              w_en;
    logic [psf_pkg::SUM_W-1:0]         w_sum;
    psf_pkg::t_side                    w_side_f, w_side_s;
    logic [psf_pkg::ROOT_W-1:0]        w_root;
    logic [2:0][psf_pkg::U_W-1:0]      w_quo;
    psf_pkg::t_mid                     w_mid;
    psf_pkg::t_res                     w_res;

    // whole pipe moves unless the output word is held
    assign w_en       = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    psf_front u_front (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_pa   ({i_in.pos_a_z, i_in.pos_a_y, i_in.pos_a_x}),
        .i_pb   ({i_in.pos_b_z, i_in.pos_b_y, i_in.pos_b_x}),
        .i_rest (i_in.rest_length),
        .i_k    (i_in.spring_constant),
        .o_sum  (w_sum),
        .o_side (w_side_f)
    );

    psf_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_sum  (w_sum),
        .i_side (w_side_f),
        .o_root (w_root),
        .o_side (w_side_s)
    );

    psf_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_root (w_root),
        .i_side (w_side_s),
        .o_quo  (w_quo),
        .o_mid  (w_mid)
    );

    psf_back u_back (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_quo  (w_quo),
        .i_mid  (w_mid),
        .o_res  (w_res)
    );

    assign o_out.valid      = r_vld[LAT-1];
    assign o_out.force_x    = w_res.frc[0];
    assign o_out.force_y    = w_res.frc[1];
    assign o_out.force_z    = w_res.frc[2];
    assign o_out.stretch    = w_res.stretch;
    assign o_out.distance   = w_res.span;
    assign o_out.degenerate = w_res.degen;

    // degenerate word carries zero force and zero distance
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.degenerate |->
            o_out.force_x == '0 && o_out.force_y == '0 && o_out.force_z == '0
            && o_out.distance == '0)
        else $error("degenerate word with non-zero force or distance");

    // with zero distance the stretch is minus the rest length, saturated, never positive
    a_degen_stretch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.degenerate |-> o_out.stretch[psf_pkg::POS_W-1]
            || o_out.stretch == '0)
        else $error("degenerate word with positive stretch");

    // reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid straight after reset");

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the spring force unit: directed table, random pairs, scoreboard.
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM       = 400;

    typedef struct packed {
        logic signed [31:0] ax, ay, az, bx, by, bz;
        logic [31:0]        rest, k;
    } t_pair;

    typedef struct packed {
        logic signed [31:0] fx, fy, fz, stretch;
        logic [31:0]        span;
        logic               degen;
    } t_force;

    // directed row: has_exp marks a hand-typed expected word
    typedef struct packed {
        t_pair  pair;
        logic   has_exp;
        t_force exp_word;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    psf_in_if  in_ch();
    psf_out_if out_ch();

    paired_spring_force_unit i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    t_force force_queue[$];
    int     n_fail = 0;
    int     idle_cycles = 0;
    int     src_idle_pct = 7;
    int     snk_idle_pct = 79;
    bit     hold_off = 1'b0;
    bit     src_done = 1'b0;

    // integer square root of up to 66 bits, one bit at a time
    function automatic logic [32:0] root66(input logic [65:0] n);
        logic [32:0]  r;
        logic [32:0]  c;
        logic [67:0]  sq;
        r = '0;
        for (int b = 32; b >= 0; b--) begin
            c  = r | (33'd1 << b);
            sq = 68'(c) * 68'(c);
            if (sq <= 68'(n)) r = c;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp_s(input logic neg, input logic [127:0] m);
        if (neg) return (m > 128'h8000_0000) ? 32'h8000_0000 : -m[31:0];
        return (m > 128'h7fff_ffff) ? 32'h7fff_ffff : m[31:0];
    endfunction

    // Hooke force on B with magnitude truncation at every stage
    function automatic t_force spring_force(input t_pair p);
        t_force           f;
        logic signed [32:0] d[3];
        logic [32:0]      dm[3];
        logic [65:0]      sum;
        logic [32:0]      len;
        logic signed [34:0] x;
        logic [33:0]      xm;
        logic [127:0]     kx, u, fm;
        logic [31:0]      fr[3];
        d[0] = 33'(p.ax) - 33'(p.bx);
        d[1] = 33'(p.ay) - 33'(p.by);
        d[2] = 33'(p.az) - 33'(p.bz);
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            dm[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
            sum = sum + 66'(dm[i]) * 66'(dm[i]);
        end
        len = root66(sum);
        x   = 35'(len) - 35'(p.rest);
        xm  = x[34] ? 34'(-x) : 34'(x);
        kx  = (128'(p.k) * 128'(xm)) >> psf_pkg::FRAC_BITS;
        for (int i = 0; i < 3; i++) begin
            if (len == 0) begin
                fr[i] = '0;
            end else begin
                u  = (128'(dm[i]) << psf_pkg::FRAC_BITS) / 128'(len);
                fm = (kx * u) >> psf_pkg::FRAC_BITS;
                fr[i] = clamp_s(x[34] != d[i][32], fm);
            end
        end
        f.fx = fr[0];
        f.fy = fr[1];
        f.fz = fr[2];
        f.stretch = clamp_s(x[34], 128'(xm));
        f.span    = (len > 33'hffff_ffff) ? 32'hffff_ffff : len[31:0];
        f.degen   = (len == 0);
        return f;
    endfunction

    function automatic t_pair rand_pair();
        t_pair p;
        int    m;
        m = $urandom_range(0, 3);
        p.ax = $urandom; p.ay = $urandom; p.az = $urandom;
        case (m)
            0: begin
                // small separations, mostly sane springs
                p.bx = p.ax + $signed($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
                p.by = p.ay + $signed($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
                p.bz = p.az + $signed($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
                p.rest = $urandom_range(0, 32'h3_0000);
                p.k    = $urandom_range(0, 32'h10_0000);
            end
            1: begin
                p.bx = $urandom; p.by = $urandom; p.bz = $urandom;
                p.rest = $urandom; p.k = $urandom;
            end
            2: begin
                // coinciding points now and then
                p.bx = p.ax; p.by = p.ay; p.bz = p.az;
                if ($urandom_range(0, 1)) p.bz = p.az + 1;
                p.rest = $urandom; p.k = $urandom;
            end
            default: begin
                p.bx = $urandom; p.by = p.ay; p.bz = p.az;
                p.rest = $urandom_range(0, 32'h100_0000);
                p.k    = $urandom_range(0, 32'h1_0000);
            end
        endcase
        return p;
    endfunction

    task automatic send_word(input t_pair p);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.pos_a_x         <= p.ax;
        in_ch.pos_a_y         <= p.ay;
        in_ch.pos_a_z         <= p.az;
        in_ch.pos_b_x         <= p.bx;
        in_ch.pos_b_y         <= p.by;
        in_ch.pos_b_z         <= p.bz;
        in_ch.rest_length     <= p.rest;
        in_ch.spring_constant <= p.k;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    function automatic t_row hand_row(input t_pair p, input t_force f);
        t_row r;
        r.pair = p; r.has_exp = 1'b1; r.exp_word = f;
        return r;
    endfunction

    function automatic t_row pred_row(input t_pair p);
        t_row r;
        r.pair = p; r.has_exp = 1'b0; r.exp_word = '0;
        return r;
    endfunction

    t_row stim_table[$];

    initial begin
        in_ch.valid = 1'b0;
        in_ch.pos_a_x = '0; in_ch.pos_a_y = '0; in_ch.pos_a_z = '0;
        in_ch.pos_b_x = '0; in_ch.pos_b_y = '0; in_ch.pos_b_z = '0;
        in_ch.rest_length = '0; in_ch.spring_constant = '0;

        // coinciding at origin, zero rest: all zero, flagged
        stim_table.push_back(hand_row('0, '{0, 0, 0, 0, 0, 1'b1}));
        // coinciding, rest 1.0: stretch -1.0
        stim_table.push_back(hand_row('{5, 5, 5, 5, 5, 5, 32'h1_0000, 32'h1_0000},
                                      '{0, 0, 0, 32'hffff_0000, 0, 1'b1}));
        // coinciding, huge rest: stretch clamps negative
        stim_table.push_back(hand_row('{-1, -1, -1, -1, -1, -1, 32'hffff_ffff, 32'hffff_ffff},
                                      '{0, 0, 0, 32'h8000_0000, 0, 1'b1}));
        // unit along x, zero stiffness
        stim_table.push_back(hand_row('{32'h1_0000, 0, 0, 0, 0, 0, 0, 0},
                                      '{0, 0, 0, 32'h1_0000, 32'h1_0000, 1'b0}));
        // extreme span on all axes: distance clamps, stretch clamps
        stim_table.push_back(hand_row('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0},
                                      '{0, 0, 0, 32'h7fff_ffff, 32'hffff_ffff, 1'b0}));
        stim_table.push_back(pred_row('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'hffff_ffff, 32'hffff_ffff}));
        stim_table.push_back(pred_row('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                        0, 32'hffff_ffff}));
        stim_table.push_back(pred_row('{32'h2_0000, 32'h1_0000, -32'h3_0000, 0, 0, 0,
                                        32'h1_0000, 32'h2_0000}));
        stim_table.push_back(pred_row('{0, 0, 0, 32'h3_0000, -32'h4_0000, 0,
                                        32'h8_0000, 32'h1_8000}));
        stim_table.push_back(pred_row('{1, 0, 0, 0, 0, 0, 0, 32'hffff_ffff}));
        stim_table.push_back(pred_row('{0, -1, 0, 0, 0, 0, 32'hffff_ffff, 32'hffff_ffff}));
        stim_table.push_back(pred_row('{32'h10_0000, 32'h10_0000, 32'h10_0000,
                                        -32'h10_0000, -32'h10_0000, -32'h10_0000,
                                        32'h5_0000, 32'h7fff_ffff}));
        stim_table.push_back(pred_row('{32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0,
                                        32'h8000_0000, 32'h1_0000}));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[i]) begin
            force_queue.push_back(stim_table[i].has_exp ? stim_table[i].exp_word
                                                        : spring_force(stim_table[i].pair));
            send_word(stim_table[i].pair);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            t_pair p;
            if (n == N_RANDOM / 3) begin
                src_idle_pct = 79; snk_idle_pct = 7;
            end
            if (n == 2 * N_RANDOM / 3) begin
                src_idle_pct = 0; snk_idle_pct = 0;
            end
            p = rand_pair();
            force_queue.push_back(spring_force(p));
            send_word(p);
        end
        in_ch.valid <= 1'b0;
        src_done = 1'b1;
    end

    // receiver: random idling plus one long hold-off to back the pipe up
    initial begin
        int cnt;
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            cnt++;
            if (cnt == 300) hold_off = 1'b1;
            if (cnt == 600) hold_off = 1'b0;
            out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // word scoreboard against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (force_queue.size() == 0) begin
                $error("result word with nothing expected");
                n_fail++;
            end else begin
                t_force e;
                e = force_queue.pop_front();
                if (out_ch.force_x !== e.fx) begin
                    $error("force_x exp %h got %h", e.fx, out_ch.force_x); n_fail++;
                end
                if (out_ch.force_y !== e.fy) begin
                    $error("force_y exp %h got %h", e.fy, out_ch.force_y); n_fail++;
                end
                if (out_ch.force_z !== e.fz) begin
                    $error("force_z exp %h got %h", e.fz, out_ch.force_z); n_fail++;
                end
                if (out_ch.stretch !== e.stretch) begin
                    $error("stretch exp %h got %h", e.stretch, out_ch.stretch); n_fail++;
                end
                if (out_ch.distance !== e.span) begin
                    $error("distance exp %h got %h", e.span, out_ch.distance); n_fail++;
                end
                if (out_ch.degenerate !== e.degen) begin
                    $error("degenerate exp %b got %b", e.degen, out_ch.degenerate); n_fail++;
                end
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (!(src_done && force_queue.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        if (!src_done || force_queue.size() != 0) begin
            $display("paired_spring_force_unit regression: fail");
        end else begin
            repeat (2 * psf_pkg::LAT) @(posedge i_clk);
            if (n_fail == 0) $display("paired_spring_force_unit regression: pass");
            else $display("paired_spring_force_unit regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/psf_pkg.sv
rtl/core/psf_in_if.sv
rtl/core/psf_out_if.sv
rtl/core/psf_front.sv
rtl/core/psf_sqrt.sv
rtl/core/psf_div.sv
rtl/core/psf_back.sv
rtl/core/paired_spring_force_unit.sv
verif/tb_top.sv
